[rtl/bnlj_pkg.sv]
// ----------------------------------------------------------------------------
// bnlj_pkg
// types, codes and constants shared by the block nested loop join engine
// ----------------------------------------------------------------------------
package bnlj_pkg;

  localparam int unsigned BLOCK_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_PROBE = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_PROBE
  } bnlj_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } bnlj_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] tuple_key;
    logic [31:0] tuple_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] left_key;
    logic [31:0] left_value;
    logic [31:0] right_key;
    logic [31:0] right_value;
    logic        overflow;
    logic        last_match;
  } result_t;

  typedef struct packed {
    bnlj_op_e    op;
    logic [31:0] key;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_xfer_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } tuple_t;

endpackage

[rtl/bnlj_front.sv]
// ----------------------------------------------------------------------------
// bnlj_front
// accepts input items, decodes the action and pushes commands to the queue
// ----------------------------------------------------------------------------
module bnlj_front import bnlj_pkg::*; (
  input  logic      start,
  input  in_item_t  in_item_i,
  input  logic      q_full_i,
  output logic      busy,
  output cmd_xfer_t push_o
);

  logic accept;

  assign busy   = q_full_i;
  assign accept = start & ~q_full_i;

  always_comb begin
    push_o.valid     = 1'b0;
    push_o.cmd.op    = OP_CLEAR;
    push_o.cmd.key   = in_item_i.tuple_key;
    push_o.cmd.value = in_item_i.tuple_value;
    case (in_item_i.action)
      ACT_CLEAR: begin
        push_o.valid  = accept;
        push_o.cmd.op = OP_CLEAR;
      end
      ACT_LOAD: begin
        push_o.valid  = accept;
        push_o.cmd.op = OP_LOAD;
      end
      ACT_PROBE: begin
        push_o.valid  = accept;
        push_o.cmd.op = OP_PROBE;
      end
      default: begin
        // unused code, dropped
        push_o.valid = 1'b0;
      end
    endcase
  end

endmodule

[rtl/bnlj_queue.sv]
// ----------------------------------------------------------------------------
// bnlj_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module bnlj_queue import bnlj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_xfer_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output cmd_xfer_t head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];
  assign do_push     = push_i.valid & ~full_o;
  assign do_pop      = pop_i & head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

[rtl/bnlj_back.sv]
// ----------------------------------------------------------------------------
// bnlj_back
// executes commands: tuple buffer, fill count, probe scan and result register
// ----------------------------------------------------------------------------
module bnlj_back import bnlj_pkg::*; #(
  parameter int unsigned BLOCK_DEPTH = BLOCK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_xfer_t head_i,
  output logic      pop_o,
  output logic      result_valid_o,
  output result_t   result_o
);

  localparam int unsigned IdxW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(BLOCK_DEPTH + 1);

  tuple_t          mem_q [BLOCK_DEPTH];
  tuple_t          rdata_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;

  bnlj_state_e     state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            dvld_q, dvld_d;
  logic            dlast_q, dlast_d;
  logic [31:0]     pkey_q, pkey_d;
  logic [31:0]     pval_q, pval_d;
  tuple_t          pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  logic            res_v_q, res_v_d;
  result_t         res_q, res_d;
  logic            hit;

  assign hit = dvld_q & (rdata_q.value == pval_q);

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    dvld_d   = 1'b0;
    dlast_d  = 1'b0;
    pkey_d   = pkey_q;
    pval_d   = pval_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_q[IdxW-1:0];
    wr_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            OP_CLEAR: begin
              fill_d = '0;
            end
            OP_LOAD: begin
              if (fill_q == CntW'(BLOCK_DEPTH)) begin
                res_v_d = 1'b1;
                res_d   = '{left_key: '0, left_value: '0, right_key: '0,
                            right_value: '0, overflow: 1'b1, last_match: 1'b1};
              end else begin
                wr_en  = 1'b1;
                fill_d = fill_q + CntW'(1);
              end
            end
            OP_PROBE: begin
              pkey_d = head_i.cmd.key;
              pval_d = head_i.cmd.value;
              if (fill_q != '0) begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                idx_d    = CntW'(1);
                dvld_d   = 1'b1;
                dlast_d  = (fill_q == CntW'(1));
                pend_v_d = 1'b0;
                state_d  = ST_SCAN;
              end
            end
            default: begin
              fill_d = fill_q;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_q < fill_q) begin
          rd_en   = 1'b1;
          idx_d   = idx_q + CntW'(1);
          dvld_d  = 1'b1;
          dlast_d = ((idx_q + CntW'(1)) == fill_q);
        end
        if (hit) begin
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = '{left_key: pkey_q, left_value: pval_q, right_key: pend_q.key,
                        right_value: pend_q.value, overflow: 1'b0, last_match: 1'b0};
          end
          pend_d   = rdata_q;
          pend_v_d = 1'b1;
        end
        if (dlast_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_v_q) begin
          res_v_d = 1'b1;
          res_d   = '{left_key: pkey_q, left_value: pval_q, right_key: pend_q.key,
                      right_value: pend_q.value, overflow: 1'b0, last_match: 1'b1};
        end
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      idx_q    <= '0;
      dvld_q   <= 1'b0;
      dlast_q  <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      dvld_q   <= dvld_d;
      dlast_q  <= dlast_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkey_q <= pkey_d;
    pval_q <= pval_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q[IdxW-1:0]] <= '{key: head_i.cmd.key, value: head_i.cmd.value};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

[rtl/block_nested_loop_join.sv]
// ----------------------------------------------------------------------------
// block_nested_loop_join
// block nested loop equi-join engine with buffered right tuples
//
//   channel   signals                        transfer when
//   input     start, busy, in_item_i         start high and busy low
//   result    result_valid_o, result_o       result_valid_o high, one cycle
//
// a command is registered in the command queue and waits there until it is
// at the head and the back end is idle. clear, load and a probe of an empty
// buffer are executed in the idle state; a probe of a non-empty buffer scans
// the buffer memory read port one entry per cycle, then flushes the match.
// each match is held until the next match or the end of the scan, then
// registered; results come at most one per cycle.
// busy rises when the two-entry command queue is full.
// reset empties the queue and the fill count; buffer contents are not reset.
// the receiver cannot stall results.
// ----------------------------------------------------------------------------
module block_nested_loop_join import bnlj_pkg::*; #(
  parameter int unsigned BLOCK_DEPTH = BLOCK_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item_i,
  output logic     result_valid_o,
  output result_t  result_o
);

  cmd_xfer_t push;
  cmd_xfer_t head;
  logic      q_full;
  logic      pop;

  bnlj_front u_front (
    .start     (start),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .busy      (busy),
    .push_o    (push)
  );

  bnlj_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  bnlj_back #(
    .BLOCK_DEPTH (BLOCK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
